@@ design/mqrb_pkg.sv @@
package mqrb_pkg;

    // field widths fixed by the stream format
    localparam int BYTE_W = 8;
    localparam int QID_W  = 4;
    localparam int OCC_W  = 9;
    localparam int KIND_W = 3;
    localparam int CMD_W  = 2;
    localparam int CAP_W  = 9;
    localparam int NQ_W   = 5;
    localparam int CFG_W  = 9;
    localparam int RESULT_LIMIT = 16;

    // command codes (s_tuser)
    localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd2;

    // result kinds (m_tuser)
    localparam logic [KIND_W-1:0] KIND_PUSH_OK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_ERR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_OK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_ERR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REPORT   = 3'd4;

    // configuration register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_QUEUES   = 1'b1;

    typedef enum logic [1:0] {
        OP_REPORT,
        OP_ENQ,
        OP_ENQ_REJECT,
        OP_DEQ
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [BYTE_W-1:0]   data;
        logic [QID_W-1:0]    queue;
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } back_state_t;

endpackage

@@ design/mqrb_front.sv @@
module mqrb_front (
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // byte_in[7:0], target_queue[11:8]
    input  logic [mqrb_pkg::CMD_W-1:0] s_tuser,   // cmd[1:0]
    input  logic [mqrb_pkg::NQ_W-1:0]  eff_queues,
    input  logic                       op_full,
    output logic                       op_push,
    output mqrb_pkg::op_t              op_data
);
    import mqrb_pkg::*;

    logic [BYTE_W-1:0] in_byte;
    logic [QID_W-1:0]  in_queue;
    logic              known_cmd;

    assign in_byte  = s_tdata[7:0];
    assign in_queue = s_tdata[11:8];
    assign s_tready = !op_full;

    always_comb begin
        known_cmd      = 1'b1;
        op_data.data   = in_byte;
        op_data.queue  = in_queue;
        op_data.kind   = OP_REPORT;
        unique case (s_tuser)
            CMD_REPORT: begin
                op_data.kind = OP_REPORT;
            end
            CMD_ENQUEUE: begin
                // targets outside the active set never reach the store
                if (NQ_W'(in_queue) >= eff_queues) begin
                    op_data.kind = OP_ENQ_REJECT;
                end else begin
                    op_data.kind = OP_ENQ;
                end
            end
            CMD_DEQUEUE: begin
                op_data.kind = OP_DEQ;
            end
            default: begin
                known_cmd = 1'b0;   // unused code, dropped
            end
        endcase
    end

    assign op_push = s_tvalid && !op_full && known_cmd;

endmodule

@@ design/mqrb_op_fifo.sv @@
module mqrb_op_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mqrb_pkg::op_t push_data,
    input  logic          pop,
    output mqrb_pkg::op_t pop_data,
    output logic          full,
    output logic          empty
);
    import mqrb_pkg::*;

    op_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/mqrb_back.sv @@
module mqrb_back #(
    parameter int NQ          = 16,
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        op_empty,
    input  mqrb_pkg::op_t               op_data,
    output logic                        op_pop,
    input  logic [mqrb_pkg::CAP_W-1:0]  eff_cap,
    input  logic [mqrb_pkg::NQ_W-1:0]   eff_queues,
    input  logic                        cap_clear,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,
    output logic [mqrb_pkg::KIND_W-1:0] m_tuser,
    output logic                        m_tlast
);
    import mqrb_pkg::*;

    localparam int QW     = (NQ > 1) ? $clog2(NQ) : 1;
    localparam int PW_RAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    // a pointer never passes the capacity register's range
    localparam int PW     = (PW_RAW > CAP_W) ? CAP_W : PW_RAW;
    localparam int MEM_N  = NQ << PW;

    back_state_t          state_reg, state_next;
    logic [QW-1:0]        idx_reg, idx_next;
    op_kind_t             walk_kind_reg, walk_kind_next;

    logic [CAP_W-1:0]     head_reg [NQ];
    logic [OCC_W-1:0]     count_reg [NQ];

    logic [BYTE_W-1:0]    mem [MEM_N];
    logic [BYTE_W-1:0]    rd_data_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    out_kind_reg, out_kind_next;
    logic [QID_W-1:0]     out_id_reg, out_id_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic [OCC_W-1:0]     out_occ_reg, out_occ_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_mem_reg, out_mem_next;
    logic                 out_load;

    logic [QW-1:0]        sel_q;
    logic [CAP_W-1:0]     cur_head;
    logic [OCC_W-1:0]     cur_cnt;
    logic [CAP_W:0]       tail_sum;
    logic [CAP_W-1:0]     tail;
    logic [CAP_W:0]       head_inc;
    logic [CAP_W-1:0]     head_wrap;
    logic                 can_issue;
    logic                 walk_last;
    logic                 mem_we, mem_rd;
    logic                 head_we, cnt_we;
    logic [CAP_W-1:0]     head_wval;
    logic [OCC_W-1:0]     cnt_wval;

    assign sel_q     = (state_reg == BK_IDLE) ? op_data.queue[QW-1:0] : idx_reg;
    assign cur_head  = head_reg[sel_q];
    assign cur_cnt   = count_reg[sel_q];
    assign can_issue = !out_valid_reg || m_tready;
    assign walk_last = ((NQ_W'(idx_reg) + NQ_W'(1)) == eff_queues);

    // tail = (head + count) wrapped once at the capacity
    assign tail_sum  = {1'b0, cur_head} + {1'b0, cur_cnt};
    assign tail      = (tail_sum >= {1'b0, eff_cap}) ? CAP_W'(tail_sum - {1'b0, eff_cap})
                                                     : tail_sum[CAP_W-1:0];
    assign head_inc  = {1'b0, cur_head} + (CAP_W+1)'(1);
    assign head_wrap = (head_inc >= {1'b0, eff_cap}) ? '0 : head_inc[CAP_W-1:0];

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        walk_kind_next = walk_kind_reg;
        op_pop         = 1'b0;
        mem_we         = 1'b0;
        mem_rd         = 1'b0;
        head_we        = 1'b0;
        cnt_we         = 1'b0;
        head_wval      = head_wrap;
        cnt_wval       = cur_cnt;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_byte_next  = out_byte_reg;
        out_occ_next   = out_occ_reg;
        out_last_next  = out_last_reg;
        out_mem_next   = out_mem_reg;

        unique case (state_reg)
            BK_IDLE: begin
                if (!op_empty && can_issue) begin
                    op_pop        = 1'b1;
                    out_id_next   = op_data.queue;
                    out_byte_next = '0;
                    out_occ_next  = '0;
                    out_last_next = 1'b1;
                    out_mem_next  = 1'b0;
                    out_kind_next = KIND_PUSH_ERR;
                    unique case (op_data.kind)
                        OP_ENQ: begin
                            out_load = 1'b1;
                            if (cur_cnt < OCC_W'(eff_cap)) begin
                                mem_we        = 1'b1;
                                cnt_we        = 1'b1;
                                cnt_wval      = cur_cnt + OCC_W'(1);
                                out_kind_next = KIND_PUSH_OK;
                                out_byte_next = op_data.data;
                            end
                        end
                        OP_ENQ_REJECT: begin
                            out_load = 1'b1;
                        end
                        OP_REPORT, OP_DEQ: begin
                            walk_kind_next = op_data.kind;
                            idx_next       = '0;
                            state_next     = BK_WALK;
                        end
                    endcase
                end
            end
            BK_WALK: begin
                if (can_issue) begin
                    out_load      = 1'b1;
                    out_id_next   = QID_W'(idx_reg);
                    out_byte_next = '0;
                    out_occ_next  = '0;
                    out_last_next = walk_last;
                    out_mem_next  = 1'b0;
                    if (walk_kind_reg == OP_REPORT) begin
                        out_kind_next = KIND_REPORT;
                        out_occ_next  = cur_cnt;
                    end else if (cur_cnt == '0) begin
                        out_kind_next = KIND_POP_ERR;
                    end else begin
                        out_kind_next = KIND_POP_OK;
                        out_mem_next  = 1'b1;
                        mem_rd        = 1'b1;
                        head_we       = 1'b1;
                        cnt_we        = 1'b1;
                        cnt_wval      = cur_cnt - OCC_W'(1);
                    end
                    if (walk_last) begin
                        state_next = BK_IDLE;
                    end else begin
                        idx_next = idx_reg + QW'(1);
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            walk_kind_reg <= OP_REPORT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            walk_kind_reg <= walk_kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // per-queue head and count, cleared together on reset or capacity change
    always_ff @(posedge aclk) begin
        if (!aresetn || cap_clear) begin
            for (int i = 0; i < NQ; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            if (head_we) begin
                head_reg[sel_q] <= head_wval;
            end
            if (cnt_we) begin
                count_reg[sel_q] <= cnt_wval;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_byte_reg <= out_byte_next;
        out_occ_reg  <= out_occ_next;
        out_last_reg <= out_last_next;
        out_mem_reg  <= out_mem_next;
    end

    // entry store: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[{sel_q, tail[PW-1:0]}] <= op_data.data;
        end
        if (mem_rd) begin
            rd_data_reg <= mem[{sel_q, cur_head[PW-1:0]}];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_occ_reg, (out_mem_reg ? rd_data_reg : out_byte_reg),
                       out_id_reg};

    a_write_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (cur_cnt < OCC_W'(eff_cap)))
        else $error("push written to a full queue");

    a_read_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_rd |-> (cur_cnt != '0))
        else $error("pop read from an empty queue");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_WALK) |-> (NQ_W'(idx_reg) < eff_queues))
        else $error("walk index beyond active queues");

    a_last_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_WALK && can_issue && walk_last) |=> (state_reg == BK_IDLE))
        else $error("walk did not end after last queue");

endmodule

@@ design/multi_queue_ring_buffer_top.sv @@
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | s_tuser: cmd[1:0]; s_tdata: byte_in[7:0],
//         |     |                    |   target_queue[11:8]
// m_      | out | m_tvalid/m_tready  | m_tuser: result_kind[2:0]; m_tlast: last_of_run;
//         |     |                    |   m_tdata: queue_id[3:0], byte_out[11:4],
//         |     |                    |   occupancy[20:12]
// cfg_    | in  | cfg_wen            | cfg_addr: 0 capacity, 1 queues in use; cfg_wdata
//
// Enqueue is handled in the back end's idle state, with no walk. Report and dequeue-all:
// the idle state takes the command, then the back-end walk visits one queue's
// head/count and store port per cycle while m_ is not stalled, up to the last active queue.
// Reset clears head pointers, counts and config at once; no clearing pass is run.
// A stalled m_ side holds the walk; a two-deep command queue lets s_ take up to two
// transactions meanwhile. Writing the capacity empties every queue.
module multi_queue_ring_buffer_top #(
    parameter int MAX_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,    // byte_in[7:0], target_queue[11:8]
    input  logic [mqrb_pkg::CMD_W-1:0]  s_tuser,    // cmd[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,    // queue_id, byte_out, occupancy
    output logic [mqrb_pkg::KIND_W-1:0] m_tuser,    // result_kind[2:0]
    output logic                        m_tlast,    // last_of_run
    input  logic                        cfg_wen,
    input  logic                        cfg_addr,
    input  logic [mqrb_pkg::CFG_W-1:0]  cfg_wdata
);
    import mqrb_pkg::*;

    // queue_id is four bits wide, so never more than sixteen queues exist
    localparam int NQ = (MAX_QUEUES > RESULT_LIMIT) ? RESULT_LIMIT : MAX_QUEUES;

    logic [CAP_W-1:0] cap_reg;
    logic [NQ_W-1:0]  qiu_reg;
    logic [CAP_W-1:0] eff_cap;
    logic [NQ_W-1:0]  eff_queues;
    logic             cap_clear;

    logic             op_push, op_pop, op_full, op_empty;
    op_t              op_in, op_out;

    // config registers: the user writes them only while idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_W'(256);
            qiu_reg <= NQ_W'(16);
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                CFG_CAPACITY: cap_reg <= cfg_wdata[CAP_W-1:0];
                CFG_QUEUES:   qiu_reg <= cfg_wdata[NQ_W-1:0];
                default: ;
            endcase
        end
    end

    assign cap_clear = cfg_wen && (cfg_addr == CFG_CAPACITY);

    // out-of-range settings clamp to the built size; zero acts as one
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CAP_W'(1);
        end else if (32'(cap_reg) > QUEUE_DEPTH) begin
            eff_cap = CAP_W'(QUEUE_DEPTH);
        end else begin
            eff_cap = cap_reg;
        end

        if (qiu_reg == '0) begin
            eff_queues = NQ_W'(1);
        end else if (32'(qiu_reg) > NQ) begin
            eff_queues = NQ_W'(NQ);
        end else begin
            eff_queues = qiu_reg;
        end
    end

    mqrb_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .eff_queues (eff_queues),
        .op_full    (op_full),
        .op_push    (op_push),
        .op_data    (op_in)
    );

    mqrb_op_fifo u_op_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (op_push),
        .push_data (op_in),
        .pop       (op_pop),
        .pop_data  (op_out),
        .full      (op_full),
        .empty     (op_empty)
    );

    mqrb_back #(
        .NQ          (NQ),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op_empty   (op_empty),
        .op_data    (op_out),
        .op_pop     (op_pop),
        .eff_cap    (eff_cap),
        .eff_queues (eff_queues),
        .cap_clear  (cap_clear),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

@@ sim/multi_queue_ring_buffer_top_tb.sv @@
`default_nettype none

module multi_queue_ring_buffer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mqrb_pkg::*;

    // command code 3 is unused by the block: accepted, dropped, no results
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int NUM_QUEUES    = 16;
    localparam int DEPTH         = 256;
    // margin for a full walk plus the two-deep command queue, with room on top
    localparam int SETTLE_CYCLES = 48;
    localparam int ITEMS_PER_PHASE = 22;

    // one result transaction, unpacked from m_tuser/m_tdata/m_tlast
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [QID_W-1:0]  qid;
        logic [BYTE_W-1:0] data;
        logic [OCC_W-1:0]  occ;
        logic              last;
    } fifo_result_t;

    // Scoreboard: own copy of the queue bank, predicts every result of an
    // accepted command and checks the result stream against it in order.
    class fifo_bank_scoreboard;
        fifo_result_t   pending[$];
        bit [7:0]       store[NUM_QUEUES][DEPTH];
        bit [7:0]       head[NUM_QUEUES];
        bit [8:0]       fill[NUM_QUEUES];
        bit [CAP_W-1:0] capacity_reg;
        bit [NQ_W-1:0]  queues_reg;
        int             errors;
        int             checked;
        int             kind_hits[5];

        function new();
            capacity_reg = 9'd256;
            queues_reg   = 5'd16;
            clear_queues();
        endfunction

        function void clear_queues();
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head[i] = '0;
                fill[i] = '0;
            end
        endfunction

        function int eff_capacity();
            int c = capacity_reg;
            if (c < 1) c = 1;
            if (c > DEPTH) c = DEPTH;
            return c;
        endfunction

        function int active_queues();
            int k = queues_reg;
            if (k < 1) k = 1;
            if (k > NUM_QUEUES) k = NUM_QUEUES;
            if (k > RESULT_LIMIT) k = RESULT_LIMIT;
            return k;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == CFG_CAPACITY) begin
                capacity_reg = value;
                clear_queues();
            end else begin
                queues_reg = value[NQ_W-1:0];
            end
        endfunction

        function void expect_result(logic [KIND_W-1:0] kind, int qid, int data, int occ,
                                    bit last);
            fifo_result_t r;
            r.kind = kind;
            r.qid  = qid[QID_W-1:0];
            r.data = data[BYTE_W-1:0];
            r.occ  = occ[OCC_W-1:0];
            r.last = last;
            pending.push_back(r);
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [7:0] data, logic [3:0] tq);
            int cap;
            int k;
            int pos;
            cap = eff_capacity();
            k   = active_queues();
            case (cmd)
                CMD_REPORT: begin
                    for (int i = 0; i < k; i++)
                        expect_result(KIND_REPORT, i, 0, fill[i], i == k - 1);
                end
                CMD_ENQUEUE: begin
                    if (tq >= k || fill[tq] >= cap) begin
                        expect_result(KIND_PUSH_ERR, tq, 0, 0, 1'b1);
                    end else begin
                        pos = head[tq] + fill[tq];
                        if (pos >= cap) pos -= cap;
                        store[tq][pos] = data;
                        fill[tq]++;
                        expect_result(KIND_PUSH_OK, tq, data, 0, 1'b1);
                    end
                end
                CMD_DEQUEUE: begin
                    for (int i = 0; i < k; i++) begin
                        if (fill[i] == 0) begin
                            expect_result(KIND_POP_ERR, i, 0, 0, i == k - 1);
                        end else begin
                            expect_result(KIND_POP_OK, i, store[i][head[i]], 0, i == k - 1);
                            pos = head[i] + 1;
                            if (pos >= cap) pos = 0;
                            head[i] = pos[7:0];
                            fill[i]--;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [KIND_W-1:0] kind, logic [23:0] tdata, logic last);
            fifo_result_t got;
            fifo_result_t want;
            got.kind = kind;
            got.qid  = tdata[3:0];
            got.data = tdata[11:4];
            got.occ  = tdata[20:12];
            got.last = last;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d q=%0d byte=%0h occ=%0d last=%0b",
                                          got.kind, got.qid, got.data, got.occ, got.last));
                return;
            end
            want = pending.pop_front();
            if (want.kind < 5) kind_hits[want.kind]++;
            if (got !== want)
                report_mismatch($sformatf(
                    "got kind=%0d q=%0d byte=%0h occ=%0d last=%0b, want kind=%0d q=%0d byte=%0h occ=%0d last=%0b",
                    got.kind, got.qid, got.data, got.occ, got.last,
                    want.kind, want.qid, want.data, want.occ, want.last));
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;     // byte_in[7:0], target_queue[11:8], zero pad
    logic [CMD_W-1:0]     s_tuser;     // cmd[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;     // queue_id[3:0], byte_out[11:4], occupancy[20:12]
    logic [KIND_W-1:0]    m_tuser;     // result_kind[2:0]
    logic                 m_tlast;     // last_of_run
    logic                 cfg_wen;
    logic                 cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;

    fifo_bank_scoreboard  book;
    int                   burst_left;
    int                   items_sent;
    int                   settings_run;

    multi_queue_ring_buffer_top #(
        .MAX_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Receiver back-pressure: a mode is held for a stretch of cycles, then
    // re-drawn. Modes: always ready, coin toss, periodic stall, mostly stalled.
    int stall_mode;
    int stall_left = 0;
    int stall_phase = 0;
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0: m_tready = 1'b1;
            1: m_tready = 1'($urandom_range(0, 1));
            2: m_tready = (stall_phase % 5) != 0;
            default: m_tready = ($urandom_range(0, 5) == 0);
        endcase
    end

    // every result transaction is checked at the edge that moves it
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            book.check_result(m_tuser, m_tdata, m_tlast);
    end

    // Offer one command and hold it until taken. The sender runs in bursts;
    // valid is only lowered when a gap follows, never between back-to-back
    // transactions.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [7:0] data, logic [3:0] tq);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {4'b0000, tq, data};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_command(cmd, data, tq);
        items_sent++;
        if (burst_left == 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = 16'($urandom);
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(0, 20);
        end else begin
            burst_left--;
        end
    endtask

    // stop offering and wait for the bank to go quiet; a short tail lets the
    // back end settle in idle before the settings change
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (book.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(logic idx, logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wen   = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(posedge aclk);
        book.write_reg(idx, value);
        @(negedge aclk);
        cfg_wen = 1'b0;
    endtask

    // Random commands, mostly pushes aimed at active queues so that queues fill,
    // wrap and overflow; pops and reports drain and observe them.
    task automatic random_commands(int count);
        int roll;
        int k;
        logic [CMD_W-1:0] cmd;
        logic [3:0] tq;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            k    = book.active_queues();
            if ($urandom_range(0, 99) < 85)
                tq = 4'($urandom_range(0, k - 1));
            else
                tq = 4'($urandom_range(0, NUM_QUEUES - 1));
            if (roll < 55)
                cmd = CMD_ENQUEUE;
            else if (roll < 75)
                cmd = CMD_DEQUEUE;
            else if (roll < 93)
                cmd = CMD_REPORT;
            else
                cmd = CMD_UNUSED;
            send_command(cmd, 8'($urandom), tq);
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_REPORT;
        cfg_wen    = 1'b0;
        cfg_addr   = CFG_CAPACITY;
        cfg_wdata  = '0;
        burst_left = 0;
        items_sent = 0;
        settings_run = 1;
        book = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // --- directed: reset settings, capacity 256 and sixteen queues ---
        send_command(CMD_REPORT,  8'h00, 4'd0);
        send_command(CMD_ENQUEUE, 8'h00, 4'd0);
        send_command(CMD_ENQUEUE, 8'hff, 4'd15);
        send_command(CMD_ENQUEUE, 8'h5a, 4'd15);
        send_command(CMD_UNUSED,  8'hff, 4'd15);     // ignored, no result
        send_command(CMD_DEQUEUE, 8'h00, 4'd0);
        send_command(CMD_DEQUEUE, 8'h00, 4'd0);      // q15 last byte, rest empty
        send_command(CMD_DEQUEUE, 8'h00, 4'd0);      // every queue empty
        send_command(CMD_REPORT,  8'h00, 4'd0);
        // hold off until every result is back before touching config
        drain_results();

        // --- capacity 2, three queues: full queue and inactive target ---
        write_config(CFG_CAPACITY, 9'd2);
        write_config(CFG_QUEUES,   9'd3);
        settings_run++;
        send_command(CMD_ENQUEUE, 8'ha5, 4'd0);
        send_command(CMD_ENQUEUE, 8'h3c, 4'd0);
        send_command(CMD_ENQUEUE, 8'hc3, 4'd0);      // full
        send_command(CMD_ENQUEUE, 8'h11, 4'd3);      // just past the active range
        send_command(CMD_ENQUEUE, 8'h22, 4'd15);
        send_command(CMD_DEQUEUE, 8'h00, 4'd0);
        send_command(CMD_REPORT,  8'h00, 4'd0);
        drain_results();

        // --- zero in both registers acts as one ---
        write_config(CFG_CAPACITY, 9'd0);
        write_config(CFG_QUEUES,   9'd0);
        settings_run++;
        send_command(CMD_ENQUEUE, 8'h81, 4'd0);
        send_command(CMD_ENQUEUE, 8'h18, 4'd0);      // full at capacity one
        send_command(CMD_ENQUEUE, 8'h7e, 4'd1);      // inactive
        send_command(CMD_DEQUEUE, 8'h00, 4'd0);
        drain_results();

        // --- random phases, each under its own settings ---
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin
                    write_config(CFG_CAPACITY, 9'd256);
                    write_config(CFG_QUEUES,   9'd16);
                end
                1: begin
                    write_config(CFG_CAPACITY, 9'd1);
                    write_config(CFG_QUEUES,   9'd1);
                end
                2: begin
                    // above the built depth and the queue count: clamped
                    write_config(CFG_CAPACITY, 9'd511);
                    write_config(CFG_QUEUES,   9'd31);
                end
                3: begin
                    write_config(CFG_CAPACITY, 9'($urandom_range(2, 6)));
                    write_config(CFG_QUEUES,   9'd16);
                end
                4: begin
                    // shrink without a capacity write: upper queues keep contents
                    write_config(CFG_QUEUES, 9'($urandom_range(2, 5)));
                end
                5: begin
                    // and grow again so they resume
                    write_config(CFG_QUEUES, 9'd16);
                end
                default: begin
                    write_config(CFG_CAPACITY, 9'($urandom_range(0, 3) == 0 ?
                                 $urandom_range(0, 511) : $urandom_range(1, 8)));
                    write_config(CFG_QUEUES, 9'($urandom_range(0, 31)));
                end
            endcase
            settings_run++;
            random_commands(ITEMS_PER_PHASE);
            drain_results();
        end

        $display("Summary: %0d commands over %0d settings, %0d results checked",
                 items_sent, settings_run, book.checked);
        $display("  push ok %0d, push err %0d, pop ok %0d, pop err %0d, reports %0d",
                 book.kind_hits[KIND_PUSH_OK], book.kind_hits[KIND_PUSH_ERR],
                 book.kind_hits[KIND_POP_OK], book.kind_hits[KIND_POP_ERR],
                 book.kind_hits[KIND_REPORT]);
        if (book.errors == 0 && book.pending.size() == 0) begin
            $display("multi_queue_ring_buffer_top_tb passed");
        end else begin
            $display("multi_queue_ring_buffer_top_tb failed");
        end
        $finish;
    end

    // watchdog: a missing result or a stuck handshake ends up here
    initial begin
        #2ms;
        $display("Timeout with %0d results outstanding", book.pending.size());
        $display("multi_queue_ring_buffer_top_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
